### rtl/wheel_speed_slip_average_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for wheel_speed_slip_average
// Implication checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_SLIP_AVERAGE_MACROS_SVH
`define WHEEL_SPEED_SLIP_AVERAGE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WSSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wssa assertion failed");
// next-cycle implication
`define WSSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wssa assertion failed");
`else
`define WSSA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define WSSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/wssa_pkg.sv
// ----------------------------------------------------------------------------
// wssa_pkg
// Widths, fixed-point constants and shared types of the wheel speed block.
// ----------------------------------------------------------------------------
`default_nettype none
package wssa_pkg;

  localparam int RPS_W  = 8;
  localparam int CIRC_W = 12;
  localparam int USED_W = 3;
  localparam int KPH_W  = 8;
  localparam int SUM_W  = RPS_W + 2;
  localparam int WHEELS = 4;

  localparam logic [CIRC_W-1:0] CIRC_RESET = 12'd2000;

  // floor(4*max/5) = (max*820) >> 10, exact for max < 256
  localparam logic [9:0] THR_MUL   = 10'd820;
  localparam int         THR_SHIFT = 10;

  // max*circ*3600/1e6 = (max*circ*9)/2500
  localparam int PROD_W  = RPS_W + CIRC_W;  // max*circ
  localparam int SCALE_W = PROD_W + 4;      // times 9
  // speed > 255 exactly when scaled product >= 256*2500
  localparam logic [SCALE_W-1:0] SAT_LIMIT = 24'd640000;
  localparam logic [KPH_W-1:0]   KPH_MAX   = 8'd255;
  // floor(y/2500) = (y*429497) >> 30 for y < 640000
  localparam int                 RECIP_W      = 19;
  localparam logic [RECIP_W-1:0] RECIP_2500   = 19'd429497;
  localparam int                 RECIP_SHIFT  = 30;

  // floor(s/3) = (s*683) >> 11 for s < 1024
  localparam logic [9:0] RECIP_3       = 10'd683;
  localparam int         RECIP_3_SHIFT = 11;

  localparam logic [USED_W-1:0] USED_ONE   = 3'd1;
  localparam logic [USED_W-1:0] USED_TWO   = 3'd2;
  localparam logic [USED_W-1:0] USED_THREE = 3'd3;
  localparam logic [USED_W-1:0] USED_FOUR  = 3'd4;

  // stage load enables, stage 2 to stage 4
  typedef struct packed {
    logic s2_en;
    logic s3_en;
    logic s4_en;
  } wssa_adv_t;

endpackage
`default_nettype wire

### rtl/wssa_in_if.sv
// ----------------------------------------------------------------------------
// wssa_in_if
// Input channel: one word of four wheel speeds.
// ----------------------------------------------------------------------------
`default_nettype none
interface wssa_in_if;
  import wssa_pkg::*;
  logic             valid;
  logic             ready;
  logic [RPS_W-1:0] left_front_rps;
  logic [RPS_W-1:0] right_front_rps;
  logic [RPS_W-1:0] left_rear_rps;
  logic [RPS_W-1:0] right_rear_rps;

  modport source(output valid, left_front_rps, right_front_rps, left_rear_rps,
                 right_rear_rps, input ready);
  modport sink(input valid, left_front_rps, right_front_rps, left_rear_rps,
               right_rear_rps, output ready);
endinterface
`default_nettype wire

### rtl/wssa_out_if.sv
// ----------------------------------------------------------------------------
// wssa_out_if
// Result channel: average, wheel count and vehicle speed.
// ----------------------------------------------------------------------------
`default_nettype none
interface wssa_out_if;
  import wssa_pkg::*;
  logic              valid;
  logic              ready;
  logic [RPS_W-1:0]  average_rps;
  logic [USED_W-1:0] wheels_used;
  logic [KPH_W-1:0]  speed_kph;
  logic              speed_saturated;

  modport source(output valid, average_rps, wheels_used, speed_kph, speed_saturated,
                 input ready);
  modport sink(input valid, average_rps, wheels_used, speed_kph, speed_saturated,
               output ready);
endinterface
`default_nettype wire

### rtl/wssa_cfg_if.sv
// ----------------------------------------------------------------------------
// wssa_cfg_if
// Configuration write channel: wheel circumference.
// ----------------------------------------------------------------------------
`default_nettype none
interface wssa_cfg_if;
  import wssa_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIRC_W-1:0] wheel_circumference_mm;

  modport source(output valid, wheel_circumference_mm, input ready);
  modport sink(input valid, wheel_circumference_mm, output ready);
endinterface
`default_nettype wire

### rtl/wssa_speed.sv
// ----------------------------------------------------------------------------
// wssa_speed
// Vehicle speed path, stages 2 to 4: product, scale and reciprocal divide.
// ----------------------------------------------------------------------------
`default_nettype none
module wssa_speed (
  input  wire                         clk,
  input  wssa_pkg::wssa_adv_t         adv,
  input  wire [wssa_pkg::RPS_W-1:0]   max_rps,
  input  wire [wssa_pkg::CIRC_W-1:0]  circ_mm,
  output logic [wssa_pkg::KPH_W-1:0]  speed_kph,
  output logic                        speed_saturated
);
  import wssa_pkg::*;

  localparam int QPROD_W = PROD_W + RECIP_W;

  logic [PROD_W-1:0]  prod_r;
  logic [SCALE_W-1:0] scale_nxt;
  logic [PROD_W-1:0]  scale_r;    // only low bits matter when not saturated
  logic               sat3_r;
  logic [QPROD_W-1:0] quot_prod;
  logic [KPH_W-1:0]   kph_r, kph_nxt;
  logic               sat_r;

  // x9 as shift and add
  assign scale_nxt = {4'b0, prod_r} + {1'b0, prod_r, 3'b0};
  assign quot_prod = QPROD_W'(scale_r) * QPROD_W'(RECIP_2500);
  assign kph_nxt   = sat3_r ? KPH_MAX : quot_prod[RECIP_SHIFT +: KPH_W];

  always_ff @(posedge clk) begin
    if (adv.s2_en) begin
      prod_r <= PROD_W'(max_rps) * PROD_W'(circ_mm);
    end
    if (adv.s3_en) begin
      scale_r <= scale_nxt[PROD_W-1:0];
      sat3_r  <= (scale_nxt >= SAT_LIMIT);
    end
    if (adv.s4_en) begin
      kph_r <= kph_nxt;
      sat_r <= sat3_r;
    end
  end

  assign speed_kph       = kph_r;
  assign speed_saturated = sat_r;

endmodule
`default_nettype wire

### rtl/wheel_speed_slip_average.sv
// ----------------------------------------------------------------------------
// wheel_speed_slip_average
// Slip-filtered mean wheel speed and vehicle speed from four wheel speeds.
// ----------------------------------------------------------------------------
// Takes one word of four wheel speeds (rev/s) per clock and returns one
// result word per input, in order. The fastest wheel sets a slip threshold
// of floor(4*max/5); wheels at or above it are averaged (truncated) and
// counted (1 to 4). Vehicle speed is floor(max*circumference*3600/1e6)
// km/h, clamped at 255 with a flag. Throughput is one word per cycle, set
// by the four-stage pipeline, unless stalled; stage 4 is the output register,
// so a word can enter while a result waits and bubbles collapse under
// backpressure. The circumference register resets to 2000 mm; the user writes
// it over the cfg channel only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none
`include "wheel_speed_slip_average_macros.svh"
module wheel_speed_slip_average (
  input  wire        clk,
  input  wire        rst_n,
  wssa_in_if.sink    in_chan,
  wssa_out_if.source out_chan,
  wssa_cfg_if.sink   cfg_chan
);
  import wssa_pkg::*;

  // configuration
  logic [CIRC_W-1:0] circ_r;

  // stage valids
  logic v1_r, v2_r, v3_r, v4_r;
  wssa_adv_t adv;
  logic s1_en;

  // stage 1: wheel speeds and maximum
  logic [RPS_W-1:0] rps1_r [WHEELS];
  logic [RPS_W-1:0] max1_r;
  logic [RPS_W-1:0] max_a, max_b, max_nxt;

  // stage 2: threshold
  logic [RPS_W-1:0] rps2_r [WHEELS];
  logic [RPS_W-1:0] thr2_r;
  logic [17:0]      thr_prod;

  // stage 3: sum and count of kept wheels
  logic [SUM_W-1:0]  sum3_r, sum_nxt;
  logic [USED_W-1:0] used3_r, used_nxt;
  logic [SUM_W-1:0]  term [WHEELS];
  logic [WHEELS-1:0] keep;

  // stage 4: average
  logic [RPS_W-1:0]  avg4_r, avg_nxt;
  logic [USED_W-1:0] used4_r;
  logic [20:0]       third_prod;

  // ready chain: a stage loads when empty or when its successor loads
  assign adv.s4_en = !v4_r || out_chan.ready;
  assign adv.s3_en = !v3_r || adv.s4_en;
  assign adv.s2_en = !v2_r || adv.s3_en;
  assign s1_en     = !v1_r || adv.s2_en;

  assign in_chan.ready  = s1_en;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      circ_r <= CIRC_RESET;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        circ_r <= cfg_chan.wheel_circumference_mm;
      end
      if (s1_en)     v1_r <= in_chan.valid;
      if (adv.s2_en) v2_r <= v1_r;
      if (adv.s3_en) v3_r <= v2_r;
      if (adv.s4_en) v4_r <= v3_r;
    end
  end

  // stage 1: two-level max tree
  assign max_a   = (in_chan.left_front_rps > in_chan.right_front_rps) ?
                   in_chan.left_front_rps : in_chan.right_front_rps;
  assign max_b   = (in_chan.left_rear_rps > in_chan.right_rear_rps) ?
                   in_chan.left_rear_rps : in_chan.right_rear_rps;
  assign max_nxt = (max_a > max_b) ? max_a : max_b;

  // stage 2: floor(4*max/5) by reciprocal
  assign thr_prod = 18'(max1_r) * 18'(THR_MUL);

  // stage 3: compare against threshold, add the kept wheels
  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      keep[i] = (rps2_r[i] >= thr2_r);
      term[i] = keep[i] ? SUM_W'(rps2_r[i]) : '0;
    end
    sum_nxt  = (term[0] + term[1]) + (term[2] + term[3]);
    used_nxt = USED_W'($countones(keep));
  end

  // stage 4: divide by 1..4; thirds by reciprocal
  assign third_prod = 21'(sum3_r) * 21'(RECIP_3);

  always_comb begin
    case (used3_r)
      USED_TWO:   avg_nxt = sum3_r[RPS_W:1];
      USED_THREE: avg_nxt = third_prod[RECIP_3_SHIFT +: RPS_W];
      USED_FOUR:  avg_nxt = sum3_r[RPS_W+1:2];
      default:    avg_nxt = sum3_r[RPS_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      rps1_r[0] <= in_chan.left_front_rps;
      rps1_r[1] <= in_chan.right_front_rps;
      rps1_r[2] <= in_chan.left_rear_rps;
      rps1_r[3] <= in_chan.right_rear_rps;
      max1_r    <= max_nxt;
    end
    if (adv.s2_en) begin
      rps2_r <= rps1_r;
      thr2_r <= thr_prod[THR_SHIFT +: RPS_W];
    end
    if (adv.s3_en) begin
      sum3_r  <= sum_nxt;
      used3_r <= used_nxt;
    end
    if (adv.s4_en) begin
      avg4_r  <= avg_nxt;
      used4_r <= used3_r;
    end
  end

  // speed path runs in lockstep with stages 2..4
  wssa_speed u_speed (
    .clk             (clk),
    .adv             (adv),
    .max_rps         (max1_r),
    .circ_mm         (circ_r),
    .speed_kph       (out_chan.speed_kph),
    .speed_saturated (out_chan.speed_saturated)
  );

  assign out_chan.valid       = v4_r;
  assign out_chan.average_rps = avg4_r;
  assign out_chan.wheels_used = used4_r;

  // fastest wheel always passes the threshold
  `WSSA_ASSERT_NOW(a_used_range, clk, rst_n, out_chan.valid, (used4_r != 3'd0) && (used4_r <= USED_FOUR))
  // clamp flag and clamped value agree
  `WSSA_ASSERT_NOW(a_sat_clamp, clk, rst_n, out_chan.valid && out_chan.speed_saturated, out_chan.speed_kph == KPH_MAX)
  // an accepted word is in stage 1 on the next cycle
  `WSSA_ASSERT_NEXT(a_accept_s1, clk, rst_n, in_chan.valid && in_chan.ready, v1_r)

endmodule
`default_nettype wire

### tb/wheel_speed_slip_average_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wheel_speed_slip_average_checker
// Watches the input, result and circumference channels. For every accepted
// input word it works out the slip-filtered mean and the vehicle speed, and
// compares each result word, field by field, in order.
// ----------------------------------------------------------------------------
module wheel_speed_slip_average_checker (
  input  wire clk,
  input  wire rst_n,
  wssa_in_if  in_mon,
  wssa_out_if out_mon,
  wssa_cfg_if cfg_mon,
  output int  errors,
  output int  pending
);
  import wssa_pkg::*;

  typedef struct packed {
    logic [RPS_W-1:0]  average_rps;
    logic [USED_W-1:0] wheels_used;
    logic [KPH_W-1:0]  speed_kph;
    logic              speed_saturated;
  } wheel_result_t;

  localparam logic [CIRC_W-1:0] CIRC_AT_RESET = 12'd2000;
  localparam int                MAX_PRINTED   = 40;

  logic [CIRC_W-1:0] circ_mm;
  wheel_result_t     speed_results_due[$];
  int                mismatch_count = 0;
  int                due_count = 0;

  assign errors  = mismatch_count;
  assign pending = due_count;

  // wheels within 20 % of the fastest are averaged; speed comes from the fastest
  function automatic wheel_result_t slip_filter_speed(
    input logic [WHEELS-1:0][RPS_W-1:0] rps,
    input logic [CIRC_W-1:0]            circ
  );
    int unsigned     fastest;
    int unsigned     thr;
    int unsigned     sum;
    int unsigned     used;
    int              i;
    longint unsigned kph_full;
    wheel_result_t   r;
    fastest = 0;
    for (i = 0; i < WHEELS; i++) begin
      if (rps[i] > fastest) fastest = rps[i];
    end
    thr  = (fastest * 4) / 5;
    sum  = 0;
    used = 0;
    for (i = 0; i < WHEELS; i++) begin
      if (rps[i] >= thr) begin
        sum  += rps[i];
        used += 1;
      end
    end
    r.average_rps = (used != 0) ? RPS_W'(sum / used) : '0;
    r.wheels_used = USED_W'(used);
    kph_full = (64'(fastest) * 64'(circ) * 64'd3600) / 64'd1000000;
    if (kph_full > 64'd255) begin
      r.speed_kph       = 8'd255;
      r.speed_saturated = 1'b1;
    end else begin
      r.speed_kph       = KPH_W'(kph_full);
      r.speed_saturated = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    wheel_result_t want;
    if (!rst_n) begin
      circ_mm = CIRC_AT_RESET;
      speed_results_due.delete();
    end else begin
      // result side first: a word leaving now is always older than one entering
      if (out_mon.valid && out_mon.ready) begin
        if (speed_results_due.size() == 0) begin
          report_mismatch($sformatf("result word with none due: avg %0d used %0d kph %0d",
                                    out_mon.average_rps, out_mon.wheels_used,
                                    out_mon.speed_kph));
        end else begin
          want = speed_results_due.pop_front();
          if (out_mon.average_rps !== want.average_rps)
            report_mismatch($sformatf("average_rps got %0d want %0d",
                                      out_mon.average_rps, want.average_rps));
          if (out_mon.wheels_used !== want.wheels_used)
            report_mismatch($sformatf("wheels_used got %0d want %0d",
                                      out_mon.wheels_used, want.wheels_used));
          if (out_mon.speed_kph !== want.speed_kph)
            report_mismatch($sformatf("speed_kph got %0d want %0d",
                                      out_mon.speed_kph, want.speed_kph));
          if (out_mon.speed_saturated !== want.speed_saturated)
            report_mismatch($sformatf("speed_saturated got %0b want %0b",
                                      out_mon.speed_saturated, want.speed_saturated));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        speed_results_due.push_back(slip_filter_speed(
          {in_mon.right_rear_rps, in_mon.left_rear_rps,
           in_mon.right_front_rps, in_mon.left_front_rps}, circ_mm));
      end
      if (cfg_mon.valid && cfg_mon.ready) circ_mm = cfg_mon.wheel_circumference_mm;
    end
    due_count = speed_results_due.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives wheel speed words and circumference writes into the slip filter,
// with random idling on both channels; the checker does all comparison and
// this top only gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import wssa_pkg::*;

  localparam int NUM_PHASES       = 7;
  localparam int RANDOM_PER_PHASE = 228;
  localparam int DRAIN_CYCLES     = 10;   // pipeline is four deep
  localparam int CFG_SETTLE       = 8;
  localparam int NUM_DIRECTED     = 18;

  // directed words, packed as {right_rear, left_rear, right_front, left_front}
  localparam logic [WHEELS-1:0][RPS_W-1:0] DIRECTED_WORDS [NUM_DIRECTED] = '{
    {8'd0,   8'd0,   8'd0,   8'd0},    // all stopped: all four count
    {8'd255, 8'd255, 8'd255, 8'd255},  // all at top speed
    {8'd0,   8'd0,   8'd0,   8'd255},  // single fast wheel in each position
    {8'd0,   8'd0,   8'd255, 8'd0},
    {8'd0,   8'd255, 8'd0,   8'd0},
    {8'd255, 8'd0,   8'd0,   8'd0},
    {8'd0,   8'd203, 8'd204, 8'd255},  // threshold 204: 204 in, 203 out
    {8'd4,   8'd3,   8'd4,   8'd5},    // threshold 4
    {8'd0,   8'd0,   8'd0,   8'd1},    // threshold 0: stopped wheels count
    {8'd1,   8'd1,   8'd1,   8'd2},    // threshold 1, mean truncates
    {8'd252, 8'd253, 8'd254, 8'd255},  // mean 253.5 truncates
    {8'd7,   8'd8,   8'd9,   8'd10},   // threshold 8
    {8'd81,  8'd79,  8'd80,  8'd100},  // threshold 80
    {8'd199, 8'd159, 8'd160, 8'd200},  // threshold 160
    {8'd0,   8'd0,   8'd0,   8'd35},   // 252 km/h at 2000 mm, just below clamp
    {8'd20,  8'd30,  8'd35,  8'd36},   // 259 km/h: clamped
    {8'h55,  8'hAA,  8'h55,  8'hAA},   // alternating bits
    {8'hAA,  8'h55,  8'hAA,  8'h55}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  bit                quiet = 1'b0;   // final stretch: no idling either side
  int                idle_level = 0; // 0 = no idling, 3 = heaviest
  logic [CIRC_W-1:0] circ_now;
  int                errors;
  int                pending;

  wssa_in_if  in_chan();
  wssa_out_if out_chan();
  wssa_cfg_if cfg_chan();

  always #4 clk = ~clk;

  wheel_speed_slip_average i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  wheel_speed_slip_average_checker i_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_chan),
    .out_mon (out_chan),
    .cfg_mon (cfg_chan),
    .errors  (errors),
    .pending (pending)
  );

  // Random word: wheels bunched near the slip threshold, plus plain
  // noise, crawling speeds, one spinning wheel and speeds around the clamp.
  function automatic logic [WHEELS-1:0][RPS_W-1:0] make_wheels();
    logic [WHEELS-1:0][RPS_W-1:0] w;
    int                           kind;
    int                           top;
    int                           lo;
    int                           i;
    kind = $urandom_range(0, 9);
    top  = $urandom_range(1, 255);
    lo   = (top * 3) / 4;
    // speed clamps once top >= ceil(256e6 / (circ * 3600))
    if (kind >= 8 && circ_now != 0) begin
      lo = (256000000 + circ_now * 3600 - 1) / (circ_now * 3600);
      if (lo <= 256) top = $urandom_range(lo > 1 ? lo - 1 : 0, lo > 255 ? 255 : lo);
      lo = 0;
    end
    for (i = 0; i < WHEELS; i++) begin
      case (kind)
        0, 1:    w[i] = RPS_W'($urandom_range(0, 255));
        6:       w[i] = RPS_W'($urandom_range(0, 8));
        7, 8, 9: w[i] = RPS_W'($urandom_range(0, top));
        default: w[i] = RPS_W'($urandom_range(lo, top));
      endcase
    end
    // noise and crawl words keep their own maximum
    if (kind >= 2 && kind != 6) w[$urandom_range(0, WHEELS - 1)] = RPS_W'(top);
    return w;
  endfunction

  // one word over the input channel; called and returned at a falling edge
  task automatic send_wheels(input logic [WHEELS-1:0][RPS_W-1:0] w);
    if (!quiet && idle_level != 0 && $urandom_range(0, 15) < idle_level * 2) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.left_front_rps  <= w[0];
    in_chan.right_front_rps <= w[1];
    in_chan.left_rear_rps   <= w[2];
    in_chan.right_rear_rps  <= w[3];
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // circumference write, only once the pipeline has drained
  task automatic write_circ(input logic [CIRC_W-1:0] value);
    wait (pending == 0);
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_chan.valid                  <= 1'b1;
    cfg_chan.wheel_circumference_mm <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
    circ_now = value;
  endtask

  // result side: random stall bursts, rate set by idle_level
  initial begin : result_ready
    int stall;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && idle_level != 0 && $urandom_range(0, 15) < idle_level) begin
        stall = $urandom_range(1, 16);
        out_chan.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [CIRC_W-1:0] phase_circ [NUM_PHASES];
    int                p;
    int                n;
    in_chan.valid                   = 1'b0;
    in_chan.left_front_rps          = '0;
    in_chan.right_front_rps         = '0;
    in_chan.left_rear_rps           = '0;
    in_chan.right_rear_rps          = '0;
    cfg_chan.valid                  = 1'b0;
    cfg_chan.wheel_circumference_mm = '0;

    // phase 0 runs on the reset value; the last phase writes it back
    phase_circ[0] = 12'd2000;
    phase_circ[1] = 12'd4095;
    phase_circ[2] = 12'd0;
    phase_circ[3] = 12'd1;
    phase_circ[4] = CIRC_W'($urandom_range(0, 4095));
    phase_circ[5] = CIRC_W'($urandom_range(300, 800));  // clamp lands mid-range
    phase_circ[6] = 12'd2000;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n    <= 1'b1;
    circ_now  = 12'd2000;

    for (n = 0; n < NUM_DIRECTED; n++) send_wheels(DIRECTED_WORDS[n]);

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        in_chan.valid <= 1'b0;
        write_circ(phase_circ[p]);
      end
      quiet      = (p == NUM_PHASES - 1);
      idle_level = quiet ? 0 : $urandom_range(0, 3);
      for (n = 0; n < RANDOM_PER_PHASE; n++) send_wheels(make_wheels());
    end
    in_chan.valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("wheel_speed_slip_average verification clean");
    end else begin
      $display("wheel_speed_slip_average verification failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("wheel_speed_slip_average verification failed");
    $finish;
  end

endmodule

### wheel_speed_slip_average.f
+incdir+rtl
rtl/wssa_pkg.sv
rtl/wssa_in_if.sv
rtl/wssa_out_if.sv
rtl/wssa_cfg_if.sv
rtl/wssa_speed.sv
rtl/wheel_speed_slip_average.sv
tb/wheel_speed_slip_average_checker.sv
tb/testbench.sv
